### hdl/i2c_gsr_pkg.sv
// Shared types and constants for the I2C gas sensor read master.
// No dependencies; the core, the top and the bench import this package.
package i2c_gsr_pkg;

  // Number of bytes read from the sensor per transaction (9..16)
  localparam int unsigned READ_LEN = 9;

  // Configuration register indexes and reset values
  localparam logic [1:0] CFG_ADDR_BYTE   = 2'd0;
  localparam logic [1:0] CFG_ACK_TMO     = 2'd1;
  localparam logic [1:0] CFG_STRETCH_TMO = 2'd2;

  localparam logic [7:0]  ADDR_BYTE_RST   = 8'hB5;
  localparam logic [15:0] ACK_TMO_RST     = 16'd250;
  localparam logic [15:0] STRETCH_TMO_RST = 16'd1000;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_ACK     = 2'd1,
    ERR_STRETCH = 2'd2
  } err_e;

  typedef struct packed {
    logic [7:0]  read_address_byte;
    logic [15:0] ack_timeout_ticks;
    logic [15:0] stretch_timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic start_read;
    logic sda_sample;
    logic scl_sample;
  } item_t;

  typedef struct packed {
    logic        scl_level;
    logic        scl_drive_enable;
    logic        sda_level;
    logic        sda_drive_enable;
    logic        busy_res;
    logic        done_res;
    logic [1:0]  error_code;
    logic        reading_valid;
    logic [15:0] co2_value;
    logic [15:0] voc_value;
  } res_t;

endpackage

### hdl/i2c_gsr_if.sv
// Valid/ready channel interfaces for the I2C gas sensor read master.
// Depends on nothing; payload widths follow the sampled bus and result words.
interface i2c_gsr_in_if;
  logic valid;
  logic ready;
  logic start_read;
  logic sda_sample;
  logic scl_sample;

  modport source (output valid, output start_read, output sda_sample, output scl_sample,
                  input ready);
  modport sink (input valid, input start_read, input sda_sample, input scl_sample,
                output ready);
endinterface

interface i2c_gsr_out_if;
  logic        valid;
  logic        ready;
  logic        scl_level;
  logic        scl_drive_enable;
  logic        sda_level;
  logic        sda_drive_enable;
  logic        busy_res;
  logic        done_res;
  logic [1:0]  error_code;
  logic        reading_valid;
  logic [15:0] co2_value;
  logic [15:0] voc_value;

  modport source (output valid, output scl_level, output scl_drive_enable, output sda_level,
                  output sda_drive_enable, output busy_res, output done_res,
                  output error_code, output reading_valid, output co2_value,
                  output voc_value, input ready);
  modport sink (input valid, input scl_level, input scl_drive_enable, input sda_level,
                input sda_drive_enable, input busy_res, input done_res,
                input error_code, input reading_valid, input co2_value,
                input voc_value, output ready);
endinterface

### hdl/i2c_gsr_core.sv
// Bus sequencer: advances the I2C read transaction by one tick per step.
// Depends on i2c_gsr_pkg for the item, config and result types.
module i2c_gsr_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_en_i,
  input  i2c_gsr_pkg::item_t item_i,
  input  i2c_gsr_pkg::cfg_t  cfg_i,
  output i2c_gsr_pkg::res_t  res_o
);
  import i2c_gsr_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE, PH_START, PH_SEND, PH_WAITACK, PH_RECV, PH_ACKOUT, PH_STOP
  } phase_e;

  localparam logic [4:0] ReadLen = 5'(READ_LEN);

  phase_e      phase_q, phase_d;
  logic [2:0]  sub_q, sub_d;
  logic [3:0]  bit_cnt_q, bit_cnt_d;
  logic [3:0]  byte_idx_q, byte_idx_d;
  logic [7:0]  shift_q, shift_d;
  logic [15:0] wait_q, wait_d;
  logic [15:0] co2_q, co2_d;
  logic [15:0] voc_q, voc_d;
  logic        scl_lvl_q, scl_lvl_d, scl_en_q, scl_en_d;
  logic        sda_lvl_q, sda_lvl_d, sda_en_q, sda_en_d;
  err_e        err_q, err_d;
  logic        vld_q, vld_d;
  logic        byte_wr;
  logic [7:0]  b0_q, b1_q, b2_q, b7_q, b8_q;

  // Next state and result for one tick
  always_comb begin
    logic       last;
    logic       done;
    err_e       err_out;
    logic       vld_out;
    logic [7:0] shifted;
    logic [3:0] bit_inc;

    phase_d    = phase_q;
    sub_d      = sub_q;
    bit_cnt_d  = bit_cnt_q;
    byte_idx_d = byte_idx_q;
    shift_d    = shift_q;
    wait_d     = wait_q;
    co2_d      = co2_q;
    voc_d      = voc_q;
    scl_lvl_d  = scl_lvl_q;
    scl_en_d   = scl_en_q;
    sda_lvl_d  = sda_lvl_q;
    sda_en_d   = sda_en_q;
    err_d      = err_q;
    vld_d      = vld_q;
    byte_wr    = 1'b0;
    done       = 1'b0;
    err_out    = ERR_NONE;
    vld_out    = 1'b0;
    last       = ({1'b0, byte_idx_q} + 5'd1) >= ReadLen;
    shifted    = {shift_q[6:0], item_i.sda_sample};
    bit_inc    = bit_cnt_q + 4'd1;

    if (step_en_i) begin
      unique case (phase_q)
        PH_IDLE: begin
          if (item_i.start_read) begin
            phase_d = PH_START;
            sub_d   = 3'd0;
            err_d   = ERR_NONE;
            vld_d   = 1'b0;
          end
        end
        PH_START: begin
          sub_d = sub_q + 3'd1;
          case (sub_q)
            3'd0: begin
              sda_en_d = 1'b1;
              scl_en_d = 1'b1;
            end
            3'd1: sda_lvl_d = 1'b1;
            3'd2: scl_lvl_d = 1'b1;
            3'd3: sda_lvl_d = 1'b0;
            default: begin
              scl_lvl_d = 1'b0;
              phase_d   = PH_SEND;
              sub_d     = 3'd0;
              shift_d   = cfg_i.read_address_byte;
              bit_cnt_d = 4'd0;
            end
          endcase
        end
        PH_SEND: begin
          case (sub_q)
            3'd0: begin
              sda_en_d = 1'b1;
              sub_d    = 3'd1;
            end
            3'd1: begin
              scl_lvl_d = 1'b0;
              sub_d     = 3'd2;
            end
            3'd2: begin
              sda_lvl_d = shift_q[7];
              shift_d   = {shift_q[6:0], 1'b0};
              sub_d     = 3'd3;
            end
            3'd3: begin
              scl_lvl_d = 1'b1;
              sub_d     = 3'd4;
            end
            default: begin
              scl_lvl_d = 1'b0;
              bit_cnt_d = bit_inc;
              if (bit_inc >= 4'd8) begin
                phase_d = PH_WAITACK;
                sub_d   = 3'd0;
              end else begin
                sub_d = 3'd2;
              end
            end
          endcase
        end
        PH_WAITACK: begin
          case (sub_q)
            3'd0: begin
              scl_lvl_d = 1'b0;
              sub_d     = 3'd1;
            end
            3'd1: begin
              sda_en_d = 1'b0;
              sub_d    = 3'd2;
            end
            3'd2: begin
              scl_lvl_d = 1'b1;
              wait_d    = '0;
              sub_d     = 3'd3;
            end
            default: begin
              // Slave pulls SDA low to acknowledge; otherwise count toward timeout
              if (!item_i.sda_sample) begin
                scl_lvl_d  = 1'b0;
                phase_d    = PH_RECV;
                sub_d      = 3'd0;
                byte_idx_d = 4'd0;
              end else if (wait_q >= cfg_i.ack_timeout_ticks) begin
                err_d   = ERR_ACK;
                phase_d = PH_STOP;
                sub_d   = 3'd0;
              end else begin
                wait_d = wait_q + 16'd1;
              end
            end
          endcase
        end
        PH_RECV: begin
          case (sub_q)
            3'd0: begin
              sda_en_d  = 1'b0;
              bit_cnt_d = 4'd0;
              shift_d   = 8'd0;
              sub_d     = 3'd1;
            end
            3'd1: begin
              scl_en_d  = 1'b1;
              scl_lvl_d = 1'b0;
              sub_d     = 3'd2;
            end
            3'd2: begin
              scl_lvl_d = 1'b1;
              sub_d     = 3'd3;
            end
            3'd3: begin
              scl_en_d = 1'b0;
              wait_d   = '0;
              sub_d    = 3'd4;
            end
            default: begin
              // Sample the bit once the slave releases SCL
              if (item_i.scl_sample) begin
                shift_d   = shifted;
                scl_en_d  = 1'b1;
                bit_cnt_d = bit_inc;
                if (bit_inc >= 4'd8) begin
                  byte_wr = 1'b1;
                  phase_d = PH_ACKOUT;
                  sub_d   = 3'd0;
                end else begin
                  sub_d = 3'd1;
                end
              end else if (wait_q >= cfg_i.stretch_timeout_ticks) begin
                scl_en_d = 1'b1;
                err_d    = ERR_STRETCH;
                phase_d  = PH_STOP;
                sub_d    = 3'd0;
              end else begin
                wait_d = wait_q + 16'd1;
              end
            end
          endcase
        end
        PH_ACKOUT: begin
          case (sub_q)
            3'd0: begin
              scl_lvl_d = 1'b0;
              sub_d     = 3'd1;
            end
            3'd1: begin
              sda_en_d  = 1'b1;
              sda_lvl_d = last;
              sub_d     = 3'd2;
            end
            3'd2: begin
              scl_lvl_d = 1'b1;
              sub_d     = 3'd3;
            end
            default: begin
              scl_lvl_d = 1'b0;
              sub_d     = 3'd0;
              if (last) begin
                if (err_q == ERR_NONE && b2_q == 8'd0) begin
                  co2_d = {b0_q, b1_q};
                  voc_d = {b7_q, b8_q};
                  vld_d = 1'b1;
                end
                phase_d = PH_STOP;
              end else begin
                byte_idx_d = byte_idx_q + 4'd1;
                phase_d    = PH_RECV;
              end
            end
          endcase
        end
        PH_STOP: begin
          sub_d = sub_q + 3'd1;
          case (sub_q)
            3'd0: begin
              sda_en_d = 1'b1;
              scl_en_d = 1'b1;
            end
            3'd1: scl_lvl_d = 1'b0;
            3'd2: sda_lvl_d = 1'b0;
            3'd3: scl_lvl_d = 1'b1;
            default: begin
              sda_lvl_d = 1'b1;
              done      = 1'b1;
              err_out   = err_q;
              vld_out   = vld_q;
              phase_d   = PH_IDLE;
              sub_d     = 3'd0;
            end
          endcase
        end
        default: begin
          phase_d = PH_IDLE;
          sub_d   = 3'd0;
        end
      endcase
    end

    res_o.scl_level        = scl_lvl_d;
    res_o.scl_drive_enable = scl_en_d;
    res_o.sda_level        = sda_lvl_d;
    res_o.sda_drive_enable = sda_en_d;
    res_o.busy_res         = (phase_d != PH_IDLE);
    res_o.done_res         = done;
    res_o.error_code       = err_out;
    res_o.reading_valid    = vld_out;
    res_o.co2_value        = co2_d;
    res_o.voc_value        = voc_d;
  end

  // Hold sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      sub_q      <= '0;
      bit_cnt_q  <= '0;
      byte_idx_q <= '0;
      shift_q    <= '0;
      wait_q     <= '0;
      co2_q      <= '0;
      voc_q      <= '0;
      scl_lvl_q  <= 1'b1;
      scl_en_q   <= 1'b1;
      sda_lvl_q  <= 1'b1;
      sda_en_q   <= 1'b1;
      err_q      <= ERR_NONE;
      vld_q      <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      sub_q      <= sub_d;
      bit_cnt_q  <= bit_cnt_d;
      byte_idx_q <= byte_idx_d;
      shift_q    <= shift_d;
      wait_q     <= wait_d;
      co2_q      <= co2_d;
      voc_q      <= voc_d;
      scl_lvl_q  <= scl_lvl_d;
      scl_en_q   <= scl_en_d;
      sda_lvl_q  <= sda_lvl_d;
      sda_en_q   <= sda_en_d;
      err_q      <= err_d;
      vld_q      <= vld_d;
    end
  end

  function automatic logic [7:0] shifted_byte(input logic [7:0] s, input logic b);
    return {s[6:0], b};
  endfunction

  // Keep only the received bytes that feed the readings
  always_ff @(posedge clk_i) begin
    if (byte_wr) begin
      case (byte_idx_q)
        4'd0: b0_q <= shifted_byte(shift_q, item_i.sda_sample);
        4'd1: b1_q <= shifted_byte(shift_q, item_i.sda_sample);
        4'd2: b2_q <= shifted_byte(shift_q, item_i.sda_sample);
        4'd7: b7_q <= shifted_byte(shift_q, item_i.sda_sample);
        4'd8: b8_q <= shifted_byte(shift_q, item_i.sda_sample);
        default: ;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // An error code is only reported on the finishing tick
  a_err_with_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.error_code != ERR_NONE |-> res_o.done_res)
    else $error("error code without done");

  // A fresh reading is never flagged on an aborted transaction
  a_valid_no_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.reading_valid |-> res_o.done_res && res_o.error_code == ERR_NONE)
    else $error("reading valid with error or without done");

  // Finishing a transaction returns the sequencer to idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en_i && res_o.done_res |=> phase_q == PH_IDLE)
    else $error("done without returning to idle");

  // Idle without a request stays idle
  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en_i && phase_q == PH_IDLE && !item_i.start_read |=> phase_q == PH_IDLE)
    else $error("left idle without a start request");

  // Byte index stays inside the read length
  a_byte_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_RECV || phase_q == PH_ACKOUT |-> {1'b0, byte_idx_q} < ReadLen)
    else $error("byte index past read length");
`endif

endmodule

### hdl/i2c_gas_sensor_read_master_top.sv
// I2C gas sensor read master
// --------------------------
// Input channel req_i carries one bus tick per word: start_read plus the
// sampled SDA and SCL levels. Output channel res_o returns exactly one word
// per input word: SCL/SDA levels and drive enables for that tick, busy,
// a done pulse with error code (0 none, 1 ack timeout, 2 stretch timeout)
// and reading_valid, and the last accepted CO2 and VOC readings.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 address byte, 1 ack timeout, 2 stretch timeout); other indexes are
// ignored. Write only while no tick is in flight.
// Timing: a word accepted into the input register is stepped through the
// sequencer and captured in the result register, and shown on res_o from
// then on until taken. Throughput: one word per cycle while res_o is not
// stalled; a single sequencer step lies between input and result registers.
// Reset drives both lines high, clears the readings and returns to idle.
// When the receiver stalls, the result register holds and the input
// register fills; req_i.ready drops once both are occupied.
// Depends on i2c_gsr_pkg, i2c_gsr_if and i2c_gsr_core.
module i2c_gas_sensor_read_master_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  i2c_gsr_in_if.sink    req_i,
  i2c_gsr_out_if.source res_o,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [15:0]   cfg_data_i
);
  import i2c_gsr_pkg::*;

  cfg_t  cfg_q;
  item_t item_q;
  logic  in_vld_q;
  res_t  res_d, res_q;
  logic  out_vld_q;
  logic  adv;
  logic  step_en;

  // Advance when the result register is free or being drained
  assign adv        = !out_vld_q || res_o.ready;
  assign step_en    = in_vld_q && adv;
  assign req_i.ready = !in_vld_q || adv;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.read_address_byte     <= ADDR_BYTE_RST;
      cfg_q.ack_timeout_ticks     <= ACK_TMO_RST;
      cfg_q.stretch_timeout_ticks <= STRETCH_TMO_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ADDR_BYTE:   cfg_q.read_address_byte     <= cfg_data_i[7:0];
        CFG_ACK_TMO:     cfg_q.ack_timeout_ticks     <= cfg_data_i;
        CFG_STRETCH_TMO: cfg_q.stretch_timeout_ticks <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (req_i.ready) begin
      in_vld_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      item_q <= '{start_read: req_i.start_read, sda_sample: req_i.sda_sample,
                  scl_sample: req_i.scl_sample};
    end
  end

  i2c_gsr_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (step_en),
    .item_i    (item_q),
    .cfg_i     (cfg_q),
    .res_o     (res_d)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_en) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid            = out_vld_q;
  assign res_o.scl_level        = res_q.scl_level;
  assign res_o.scl_drive_enable = res_q.scl_drive_enable;
  assign res_o.sda_level        = res_q.sda_level;
  assign res_o.sda_drive_enable = res_q.sda_drive_enable;
  assign res_o.busy_res         = res_q.busy_res;
  assign res_o.done_res         = res_q.done_res;
  assign res_o.error_code       = res_q.error_code;
  assign res_o.reading_valid    = res_q.reading_valid;
  assign res_o.co2_value        = res_q.co2_value;
  assign res_o.voc_value        = res_q.voc_value;

endmodule

### tb/sv/i2c_gas_sensor_read_master_top_test.sv
// Self-checking bench for the I2C gas sensor read master: drives bus tick words, steps a
// cycle-exact sequencer copy per accepted word and compares every result word field by field.
// Depends on i2c_gsr_pkg, i2c_gsr_if and the i2c_gas_sensor_read_master_top RTL.
module i2c_gas_sensor_read_master_top_test;
  import i2c_gsr_pkg::*;

  localparam int RAND_WORDS  = 400;
  localparam int HOLD_CYCLES = 400;
  localparam int NO_STRETCH  = -1;
  localparam int FILL_RANDOM = 0;
  localparam int FILL_ZEROS  = 1;
  localparam int FILL_ONES   = 2;

  typedef enum logic [3:0] {
    SEQ_IDLE, SEQ_START, SEQ_SEND, SEQ_WAITACK, SEQ_RECV, SEQ_ACKOUT, SEQ_STOP
  } seq_phase_e;

  typedef struct packed {
    seq_phase_e       phase;
    logic [2:0]       sub;
    logic [3:0]       bit_cnt;
    logic [3:0]       byte_idx;
    logic [7:0]       shift;
    logic [15:0]      wait_cnt;
    logic [15:0][7:0] rx;
    logic [15:0]      co2;
    logic [15:0]      voc;
    logic             scl_lvl;
    logic             scl_en;
    logic             sda_lvl;
    logic             sda_en;
    logic [1:0]       err;
    logic             valid_l;
  } seq_state_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [15:0] cfg_data;

  i2c_gsr_in_if  req_if ();
  i2c_gsr_out_if res_if ();

  i2c_gas_sensor_read_master_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .res_o      (res_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // Register copy shared by the stimulus planner and the checker (changed only when drained)
  cfg_t       bus_cfg;
  seq_state_t plan_st;
  seq_state_t chk_st;

  item_t word_q[$];
  res_t  bus_tick_q[$];

  int words_queued;
  int words_accepted;
  int results_seen;
  int mismatch_count;
  int holds_asked;
  int holds_done;
  int hold_left;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    #60_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic seq_state_t seq_reset_state();
    seq_state_t s;
    s = '0;
    s.phase   = SEQ_IDLE;
    s.scl_lvl = 1'b1;
    s.scl_en  = 1'b1;
    s.sda_lvl = 1'b1;
    s.sda_en  = 1'b1;
    return s;
  endfunction

  // Advance the sequencer one bus tick and form the result word for that tick
  function automatic void step_sequencer(inout seq_state_t s, input cfg_t c, input item_t w,
                                         output res_t r);
    logic       last_byte;
    logic       done;
    logic [1:0] err_o;
    logic       vld_o;
    done  = 1'b0;
    err_o = ERR_NONE;
    vld_o = 1'b0;
    case (s.phase)
      SEQ_IDLE: begin
        if (w.start_read) begin
          s.phase   = SEQ_START;
          s.sub     = 3'd0;
          s.err     = ERR_NONE;
          s.valid_l = 1'b0;
        end
      end
      SEQ_START: begin
        case (s.sub)
          3'd0: begin
            s.sda_en = 1'b1;
            s.scl_en = 1'b1;
          end
          3'd1: s.sda_lvl = 1'b1;
          3'd2: s.scl_lvl = 1'b1;
          3'd3: s.sda_lvl = 1'b0;
          default: ;
        endcase
        if (s.sub >= 3'd4) begin
          s.scl_lvl = 1'b0;
          s.phase   = SEQ_SEND;
          s.sub     = 3'd0;
          s.shift   = c.read_address_byte;
          s.bit_cnt = 4'd0;
        end else begin
          s.sub = s.sub + 3'd1;
        end
      end
      SEQ_SEND: begin
        case (s.sub)
          3'd0: begin
            s.sda_en = 1'b1;
            s.sub    = 3'd1;
          end
          3'd1: begin
            s.scl_lvl = 1'b0;
            s.sub     = 3'd2;
          end
          3'd2: begin
            s.sda_lvl = s.shift[7];
            s.shift   = {s.shift[6:0], 1'b0};
            s.sub     = 3'd3;
          end
          3'd3: begin
            s.scl_lvl = 1'b1;
            s.sub     = 3'd4;
          end
          default: begin
            s.scl_lvl = 1'b0;
            s.bit_cnt = s.bit_cnt + 4'd1;
            if (s.bit_cnt >= 4'd8) begin
              s.phase = SEQ_WAITACK;
              s.sub   = 3'd0;
            end else begin
              s.sub = 3'd2;
            end
          end
        endcase
      end
      SEQ_WAITACK: begin
        case (s.sub)
          3'd0: begin
            s.scl_lvl = 1'b0;
            s.sub     = 3'd1;
          end
          3'd1: begin
            s.sda_en = 1'b0;
            s.sub    = 3'd2;
          end
          3'd2: begin
            s.scl_lvl  = 1'b1;
            s.wait_cnt = 16'd0;
            s.sub      = 3'd3;
          end
          default: begin
            if (!w.sda_sample) begin
              s.scl_lvl  = 1'b0;
              s.phase    = SEQ_RECV;
              s.sub      = 3'd0;
              s.byte_idx = 4'd0;
            end else if (s.wait_cnt >= c.ack_timeout_ticks) begin
              s.err   = ERR_ACK;
              s.phase = SEQ_STOP;
              s.sub   = 3'd0;
            end else begin
              s.wait_cnt = s.wait_cnt + 16'd1;
            end
          end
        endcase
      end
      SEQ_RECV: begin
        case (s.sub)
          3'd0: begin
            s.sda_en  = 1'b0;
            s.bit_cnt = 4'd0;
            s.shift   = 8'd0;
            s.sub     = 3'd1;
          end
          3'd1: begin
            s.scl_en  = 1'b1;
            s.scl_lvl = 1'b0;
            s.sub     = 3'd2;
          end
          3'd2: begin
            s.scl_lvl = 1'b1;
            s.sub     = 3'd3;
          end
          3'd3: begin
            s.scl_en   = 1'b0;
            s.wait_cnt = 16'd0;
            s.sub      = 3'd4;
          end
          default: begin
            if (w.scl_sample) begin
              s.shift   = {s.shift[6:0], w.sda_sample};
              s.scl_en  = 1'b1;
              s.bit_cnt = s.bit_cnt + 4'd1;
              if (s.bit_cnt >= 4'd8) begin
                s.rx[s.byte_idx] = s.shift;
                s.phase          = SEQ_ACKOUT;
                s.sub            = 3'd0;
              end else begin
                s.sub = 3'd1;
              end
            end else if (s.wait_cnt >= c.stretch_timeout_ticks) begin
              s.scl_en = 1'b1;
              s.err    = ERR_STRETCH;
              s.phase  = SEQ_STOP;
              s.sub    = 3'd0;
            end else begin
              s.wait_cnt = s.wait_cnt + 16'd1;
            end
          end
        endcase
      end
      SEQ_ACKOUT: begin
        last_byte = (int'(s.byte_idx) + 1) >= READ_LEN;
        case (s.sub)
          3'd0: begin
            s.scl_lvl = 1'b0;
            s.sub     = 3'd1;
          end
          3'd1: begin
            s.sda_en  = 1'b1;
            s.sda_lvl = last_byte;
            s.sub     = 3'd2;
          end
          3'd2: begin
            s.scl_lvl = 1'b1;
            s.sub     = 3'd3;
          end
          default: begin
            s.scl_lvl = 1'b0;
            if (last_byte) begin
              // Publish readings only on a clean transfer with a zero status byte
              if (s.err == ERR_NONE && s.rx[2] == 8'd0) begin
                s.co2     = {s.rx[0], s.rx[1]};
                s.voc     = {s.rx[7], s.rx[8]};
                s.valid_l = 1'b1;
              end
              s.phase = SEQ_STOP;
              s.sub   = 3'd0;
            end else begin
              s.byte_idx = s.byte_idx + 4'd1;
              s.phase    = SEQ_RECV;
              s.sub      = 3'd0;
            end
          end
        endcase
      end
      SEQ_STOP: begin
        case (s.sub)
          3'd0: begin
            s.sda_en = 1'b1;
            s.scl_en = 1'b1;
          end
          3'd1: s.scl_lvl = 1'b0;
          3'd2: s.sda_lvl = 1'b0;
          3'd3: s.scl_lvl = 1'b1;
          default: ;
        endcase
        if (s.sub >= 3'd4) begin
          s.sda_lvl = 1'b1;
          done      = 1'b1;
          err_o     = s.err;
          vld_o     = s.valid_l;
          s.phase   = SEQ_IDLE;
          s.sub     = 3'd0;
        end else begin
          s.sub = s.sub + 3'd1;
        end
      end
      default: begin
        s.phase = SEQ_IDLE;
        s.sub   = 3'd0;
      end
    endcase
    r.scl_level        = s.scl_lvl;
    r.scl_drive_enable = s.scl_en;
    r.sda_level        = s.sda_lvl;
    r.sda_drive_enable = s.sda_en;
    r.busy_res         = (s.phase != SEQ_IDLE);
    r.done_res         = done;
    r.error_code       = err_o;
    r.reading_valid    = vld_o;
    r.co2_value        = s.co2;
    r.voc_value        = s.voc;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 40) $display("%0t: result %0d: %s", $time, results_seen, msg);
  endtask

  task automatic check_field(input string fname, input logic [15:0] got, input logic [15:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h want %h", fname, got, want));
  endtask

  // Queue one word and advance the planner's own sequencer copy with it
  task automatic push_word(input item_t w);
    res_t r;
    step_sequencer(plan_st, bus_cfg, w, r);
    word_q.push_back(w);
    words_queued++;
  endtask

  task automatic push_idle_words(input int count);
    item_t w;
    repeat (count) begin
      w.start_read = 1'b0;
      w.sda_sample = 1'($urandom_range(0, 1));
      w.scl_sample = 1'($urandom_range(0, 1));
      push_word(w);
    end
  endtask

  // Plan one full transaction: ack behavior, stretch abort byte, status byte and data fill
  task automatic queue_transaction(input bit ack_ok, input int stretch_byte, input bit status_ok,
                                   input int fill);
    item_t w;
    push_idle_words($urandom_range(0, 3));
    w.start_read = 1'b1;
    w.sda_sample = 1'($urandom_range(0, 1));
    w.scl_sample = 1'($urandom_range(0, 1));
    push_word(w);
    while (plan_st.phase != SEQ_IDLE) begin
      // Start requests while busy must be ignored
      w.start_read = ($urandom_range(0, 7) == 0);
      w.sda_sample = 1'($urandom_range(0, 1));
      w.scl_sample = 1'($urandom_range(0, 1));
      if (plan_st.phase == SEQ_WAITACK && plan_st.sub >= 3'd3) begin
        if (!ack_ok) w.sda_sample = 1'b1;
        else if (plan_st.wait_cnt >= bus_cfg.ack_timeout_ticks) w.sda_sample = 1'b0;
      end
      if (plan_st.phase == SEQ_RECV && plan_st.sub >= 3'd4) begin
        if (stretch_byte == int'(plan_st.byte_idx)) w.scl_sample = 1'b0;
        else if (plan_st.wait_cnt >= bus_cfg.stretch_timeout_ticks) w.scl_sample = 1'b1;
        else w.scl_sample = ($urandom_range(0, 3) != 0);
        if (fill == FILL_ZEROS) w.sda_sample = 1'b0;
        else if (fill == FILL_ONES) w.sda_sample = 1'b1;
        if (plan_st.byte_idx == 4'd2) begin
          if (status_ok) w.sda_sample = 1'b0;
          else if (plan_st.bit_cnt == 4'd7 && plan_st.shift == 8'd0) w.sda_sample = 1'b1;
        end
      end
      push_word(w);
    end
  endtask

  // Wait until every queued word has its result, then let the pipe settle
  task automatic drain();
    do @(negedge clk_i);
    while (words_accepted != words_queued || results_seen != words_accepted);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    case (idx)
      CFG_ADDR_BYTE:   bus_cfg.read_address_byte     = val[7:0];
      CFG_ACK_TMO:     bus_cfg.ack_timeout_ticks     = val;
      CFG_STRETCH_TMO: bus_cfg.stretch_timeout_ticks = val;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic write_settings(input logic [7:0] addr, input logic [15:0] ack_tmo,
                                input logic [15:0] str_tmo);
    write_reg(CFG_ADDR_BYTE, {8'h00, addr});
    write_reg(CFG_ACK_TMO, ack_tmo);
    write_reg(CFG_STRETCH_TMO, str_tmo);
  endtask

  // Sender: bursts of random length separated by random gaps
  int burst_left;
  int gap_left;

  always @(posedge clk_i or negedge rst_ni) begin : word_driver
    item_t nxt;
    if (!rst_ni) begin
      req_if.valid      <= 1'b0;
      req_if.start_read <= 1'b0;
      req_if.sda_sample <= 1'b0;
      req_if.scl_sample <= 1'b0;
      burst_left        <= 0;
      gap_left          <= 0;
    end else if (!req_if.valid || req_if.ready) begin
      if (gap_left != 0) begin
        req_if.valid <= 1'b0;
        gap_left     <= gap_left - 1;
      end else if (word_q.size() != 0) begin
        nxt = word_q.pop_front();
        req_if.valid      <= 1'b1;
        req_if.start_read <= nxt.start_read;
        req_if.sda_sample <= nxt.sda_sample;
        req_if.scl_sample <= nxt.scl_sample;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 9) == 0) ? $urandom_range(4, 12)
                                                    : $urandom_range(0, 2);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: long hold on request, otherwise a rotating stall pattern
  int stall_mode;
  int mode_left;

  always @(posedge clk_i or negedge rst_ni) begin : result_receiver
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      hold_left    <= 0;
      holds_done   <= 0;
      stall_mode   <= 0;
      mode_left    <= 0;
    end else if (hold_left != 0) begin
      res_if.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (holds_done != holds_asked) begin
      res_if.ready <= 1'b0;
      hold_left    <= HOLD_CYCLES;
      holds_done   <= holds_done + 1;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        mode_left  <= $urandom_range(20, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0:       res_if.ready <= 1'b1;
        1:       res_if.ready <= ($urandom_range(0, 3) != 0);
        default: res_if.ready <= ~res_if.ready;
      endcase
    end
  end

  // Compare each result word against the oldest prediction, then predict for accepted words
  always @(posedge clk_i) begin : tick_checker
    res_t  want;
    res_t  pred;
    item_t w;
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        results_seen++;
        if (bus_tick_q.size() == 0) begin
          report_mismatch("result word with no input word outstanding");
        end else begin
          want = bus_tick_q.pop_front();
          check_field("scl_level", 16'(res_if.scl_level), 16'(want.scl_level));
          check_field("scl_drive_enable", 16'(res_if.scl_drive_enable),
                      16'(want.scl_drive_enable));
          check_field("sda_level", 16'(res_if.sda_level), 16'(want.sda_level));
          check_field("sda_drive_enable", 16'(res_if.sda_drive_enable),
                      16'(want.sda_drive_enable));
          check_field("busy_res", 16'(res_if.busy_res), 16'(want.busy_res));
          check_field("done_res", 16'(res_if.done_res), 16'(want.done_res));
          check_field("error_code", 16'(res_if.error_code), 16'(want.error_code));
          check_field("reading_valid", 16'(res_if.reading_valid), 16'(want.reading_valid));
          check_field("co2_value", res_if.co2_value, want.co2_value);
          check_field("voc_value", res_if.voc_value, want.voc_value);
        end
      end
      if (req_if.valid && req_if.ready) begin
        w.start_read = req_if.start_read;
        w.sda_sample = req_if.sda_sample;
        w.scl_sample = req_if.scl_sample;
        step_sequencer(chk_st, bus_cfg, w, pred);
        bus_tick_q.push_back(pred);
        words_accepted++;
      end
    end
  end

  // Stimulus sequence
  initial begin : stimulus
    int   base;
    int   n;
    bit   ack_ok;
    int   sb;
    int   fill;
    logic [15:0] ack_tmo;
    logic [15:0] str_tmo;

    req_if.valid      = 1'b0;
    req_if.start_read = 1'b0;
    req_if.sda_sample = 1'b0;
    req_if.scl_sample = 1'b0;
    res_if.ready      = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = CFG_ADDR_BYTE;
    cfg_data          = 16'd0;
    rst_ni            = 1'b0;
    words_queued      = 0;
    words_accepted    = 0;
    results_seen      = 0;
    mismatch_count    = 0;
    holds_asked       = 0;
    bus_cfg           = '{ADDR_BYTE_RST, ACK_TMO_RST, STRETCH_TMO_RST};
    plan_st           = seq_reset_state();
    chk_st            = seq_reset_state();

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Reset settings: clean read with all-ones data
    queue_transaction(1'b1, NO_STRETCH, 1'b1, FILL_ONES);
    // Stall the receiver while the sender keeps streaming
    holds_asked <= holds_asked + 1;
    drain();

    // Zero timeouts fail on the first bad sample; bad status keeps the readings
    write_settings(8'h00, 16'd0, 16'd0);
    queue_transaction(1'b0, NO_STRETCH, 1'b1, FILL_RANDOM);
    queue_transaction(1'b1, 1, 1'b1, FILL_RANDOM);
    queue_transaction(1'b1, NO_STRETCH, 1'b0, FILL_ZEROS);
    drain();

    // Timeouts of one: a stretch abort mid-read and an ack timeout
    write_settings(8'h80, 16'd1, 16'd1);
    queue_transaction(1'b1, 3, 1'b1, FILL_RANDOM);
    queue_transaction(1'b0, NO_STRETCH, 1'b0, FILL_RANDOM);
    drain();

    // Random transactions, new settings every few of them
    base = words_queued;
    n    = 0;
    while (words_queued - base < RAND_WORDS) begin
      if (n % 4 == 0) begin
        drain();
        ack_tmo = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                              : 16'($urandom_range(0, 40));
        str_tmo = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                              : 16'($urandom_range(0, 40));
        write_settings(8'($urandom_range(0, 255)), ack_tmo, str_tmo);
      end
      if (n == 2) holds_asked <= holds_asked + 1;
      // Keep full timeout runs short: only small registers may be run out
      ack_ok = ($urandom_range(0, 6) != 0) || (bus_cfg.ack_timeout_ticks > 16'd64);
      sb = NO_STRETCH;
      if (bus_cfg.stretch_timeout_ticks <= 16'd64 && $urandom_range(0, 6) == 0)
        sb = $urandom_range(0, READ_LEN - 1);
      case ($urandom_range(0, 9))
        0:       fill = FILL_ZEROS;
        1:       fill = FILL_ONES;
        default: fill = FILL_RANDOM;
      endcase
      if ($urandom_range(0, 9) == 0) push_idle_words($urandom_range(10, 30));
      queue_transaction(ack_ok, sb, $urandom_range(0, 9) < 7, fill);
      n++;
    end
    drain();

    if (bus_tick_q.size() != 0)
      report_mismatch($sformatf("%0d result words never arrived", bus_tick_q.size()));
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### files.f
hdl/i2c_gsr_pkg.sv
hdl/i2c_gsr_if.sv
hdl/i2c_gsr_core.sv
hdl/i2c_gas_sensor_read_master_top.sv
tb/sv/i2c_gas_sensor_read_master_top_test.sv
